[design/assert_macros.svh]
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// As above, but also checked while reset is asserted.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rvgp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rvgp_pkg;

   localparam int RawWidth      = 32;
   localparam int PixWidth      = 8;
   localparam int CsrDataWidth  = 18;
   localparam int CsrIndexWidth = 3;
   localparam int ExpWidth      = 5;
   localparam int FracWidth     = 16;
   localparam int LogWidth      = ExpWidth + FracWidth;
   localparam int ScaleWidth    = 18;
   localparam int ProdWidth     = LogWidth + ScaleWidth;
   localparam int ScaleShift    = 28;
   localparam int MagWidth      = ProdWidth - ScaleShift;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CsrValueBytes    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSignedInput   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrConversionMode = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrPostMode      = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrLogScale      = 3'd4;

   // Conversion codes; the unused code behaves as flatten.
   localparam logic [1:0] ConvFlatten = 2'd0;
   localparam logic [1:0] ConvScale   = 2'd1;
   localparam logic [1:0] ConvLog     = 2'd2;

   // Post-processing codes.
   localparam logic [1:0] PostNone   = 2'd0;
   localparam logic [1:0] PostSignum = 2'd1;
   localparam logic [1:0] PostInvert = 2'd2;
   localparam logic [1:0] PostZero   = 2'd3;

   localparam logic [PixWidth-1:0] MidLevel    = 8'd128;
   localparam logic [PixWidth-1:0] MaxLevel    = 8'd255;
   localparam logic [PixWidth-1:0] MinLevel    = 8'd0;
   localparam logic [PixWidth-1:0] PosLimit    = 8'd127;
   localparam logic [PixWidth-1:0] NegLimit    = 8'd128;
   localparam logic [MagWidth-1:0] LogSatLimit = 11'd127;

   localparam logic [2:0]  ResetValueBytes = 3'd1;
   localparam logic [17:0] ResetLogScale   = 18'd131072;

   typedef struct packed {
      logic [2:0]            value_bytes;
      logic                  signed_input;
      logic [1:0]            conversion_mode;
      logic [1:0]            post_mode;
      logic [ScaleWidth-1:0] log_scale;
   } rvgp_cfg_type;

   // Per-item results that ride alongside the logarithm.
   typedef struct packed {
      logic                neg;
      logic                zero;
      logic [PixWidth-1:0] lin_pix;
   } rvgp_side_type;

   typedef struct packed {
      rvgp_side_type         side;
      logic [ExpWidth-1:0]   exp;
      logic [FracWidth-1:0]  frac;
      logic [RawWidth-1:0]   mant;
   } rvgp_log_type;

endpackage

`default_nettype wire

[design/rvgp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rvgp_front
   import rvgp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire rvgp_cfg_type        cfg,
   input  wire logic                in_valid,
   input  wire logic [RawWidth-1:0] raw_value,
   output      logic                out_valid,
   output      rvgp_log_type        out_data
);

   // Stage A: width selection, sign, magnitude and the non-log pixel.
   logic [1:0]          bsel;
   logic [RawWidth-1:0] mask;
   logic [RawWidth-1:0] u;
   logic                sign_bit;
   logic                neg;
   logic [RawWidth-1:0] mag;
   logic [RawWidth-1:0] shifted;
   logic [PixWidth-1:0] clamp8;
   logic [PixWidth-1:0] val8;
   logic [PixWidth-1:0] lin_pix;

   logic                a_valid_ff;
   rvgp_side_type       a_side_ff;
   logic [RawWidth-1:0] a_mag_ff;

   always_comb begin
      if (cfg.value_bytes == 3'd0) begin
         bsel = 2'd0;
      end else if (cfg.value_bytes > 3'd4) begin
         bsel = 2'd3;
      end else begin
         bsel = 2'(cfg.value_bytes - 3'd1);
      end

      case (bsel)
         2'd0:    mask = 32'h0000_00FF;
         2'd1:    mask = 32'h0000_FFFF;
         2'd2:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase

      u = raw_value & mask;

      case (bsel)
         2'd0:    sign_bit = u[7];
         2'd1:    sign_bit = u[15];
         2'd2:    sign_bit = u[23];
         default: sign_bit = u[31];
      endcase

      neg     = cfg.signed_input & sign_bit;
      mag     = neg ? ((~u + 32'd1) & mask) : u;
      shifted = mag >> {bsel, 3'b000};

      if (cfg.signed_input) begin
         if (neg) begin
            clamp8 = (mag > 32'(NegLimit)) ? NegLimit : mag[PixWidth-1:0];
         end else begin
            clamp8 = (mag > 32'(PosLimit)) ? PosLimit : mag[PixWidth-1:0];
         end
      end else begin
         clamp8 = (mag > 32'(MaxLevel)) ? MaxLevel : mag[PixWidth-1:0];
      end

      val8 = (cfg.conversion_mode == ConvScale) ? shifted[PixWidth-1:0] : clamp8;

      // Signed levels are centred on mid grey; arithmetic wraps at eight bits.
      if (cfg.signed_input) begin
         lin_pix = neg ? (MidLevel - val8) : (MidLevel + val8);
      end else begin
         lin_pix = val8;
      end
   end

   // Stage B: position of the leading one.
   logic [ExpWidth-1:0] exp_c;
   logic                b_valid_ff;
   rvgp_side_type       b_side_ff;
   logic [RawWidth-1:0] b_mag_ff;
   logic [ExpWidth-1:0] b_exp_ff;

   always_comb begin
      exp_c = '0;
      for (int i = 0; i < RawWidth; i++) begin
         if (a_mag_ff[i]) begin
            exp_c = ExpWidth'(i);
         end
      end
   end

   // Stage C: normalise the magnitude so that its leading one is bit 31.
   logic [RawWidth-1:0] norm_c;

   assign norm_c = b_mag_ff << (ExpWidth'(RawWidth - 1) - b_exp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         out_valid  <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         out_valid  <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff     <= '{neg: neg, zero: (mag == '0), lin_pix: lin_pix};
         a_mag_ff      <= mag;
         b_side_ff     <= a_side_ff;
         b_mag_ff      <= a_mag_ff;
         b_exp_ff      <= exp_c;
         out_data.side <= b_side_ff;
         out_data.exp  <= b_exp_ff;
         out_data.frac <= '0;
         out_data.mant <= norm_c;
      end
   end

endmodule

`default_nettype wire

[design/rvgp_log_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module rvgp_log_step
   import rvgp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         in_valid,
   input  wire rvgp_log_type in_data,
   output      logic         out_valid,
   output      rvgp_log_type out_data
);

   // One fraction bit of log2: square the Q1.31 mantissa and renormalise.
   logic [2*RawWidth-1:0] sq;
   logic [RawWidth:0]     sq_q31;
   logic                  frac_bit;
   logic [RawWidth-1:0]   mant_in;

   assign sq       = in_data.mant * in_data.mant;
   assign sq_q31   = sq[2*RawWidth-1:RawWidth-1];
   assign frac_bit = sq_q31[RawWidth];
   assign mant_in  = frac_bit ? sq_q31[RawWidth:1] : sq_q31[RawWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data.side <= in_data.side;
         out_data.exp  <= in_data.exp;
         out_data.frac <= {in_data.frac[FracWidth-2:0], frac_bit};
         out_data.mant <= mant_in;
      end
   end

endmodule

`default_nettype wire

[design/rvgp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rvgp_back
   import rvgp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire rvgp_cfg_type        cfg,
   input  wire logic                in_valid,
   input  wire rvgp_log_type        in_data,
   output      logic                out_valid,
   output      logic [PixWidth-1:0] out_pixel
);

   logic [ProdWidth-1:0] prod;
   logic                 m_valid_ff;
   rvgp_side_type        m_side_ff;
   logic [MagWidth-1:0]  m_mag_ff;

   assign prod = {in_data.exp, in_data.frac} * cfg.log_scale;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_side_ff <= in_data.side;
         m_mag_ff  <= prod[ProdWidth-1:ScaleShift];
      end
   end

   logic [PixWidth-1:0] sat;
   logic [PixWidth-1:0] conv;
   logic [PixWidth-1:0] zero_level;

   always_comb begin
      sat        = (m_mag_ff > LogSatLimit) ? PosLimit : m_mag_ff[PixWidth-1:0];
      zero_level = cfg.signed_input ? MidLevel : MinLevel;

      if (cfg.conversion_mode == ConvLog) begin
         if (m_side_ff.zero) begin
            conv = zero_level;
         end else if (cfg.signed_input) begin
            conv = m_side_ff.neg ? (MidLevel - sat) : (MidLevel + sat);
         end else begin
            conv = m_mag_ff[PixWidth-1:0];
         end
      end else begin
         conv = m_side_ff.lin_pix;
      end

      case (cfg.post_mode)
         PostSignum: begin
            if (conv > MidLevel) begin
               out_pixel = MaxLevel;
            end else if (conv < MidLevel) begin
               out_pixel = MinLevel;
            end else begin
               out_pixel = conv;
            end
         end
         PostInvert: out_pixel = MaxLevel - conv;
         PostZero:   out_pixel = (conv == zero_level) ? MinLevel : MaxLevel;
         default:    out_pixel = conv;
      endcase
   end

   assign out_valid = m_valid_ff;

endmodule

`default_nettype wire

[design/rvgp_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module rvgp_out_buf
   import rvgp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [PixWidth-1:0] in_pixel,
   output      logic                in_ready,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [PixWidth-1:0] rsp_pixel
);

   logic                out_valid_ff;
   logic [PixWidth-1:0] out_pixel_ff;
   logic                skid_valid_ff;
   logic [PixWidth-1:0] skid_pixel_ff;
   logic                out_free;
   logic                take;

   // Upstream sees only a registered flag, never the downstream ready.
   assign in_ready = !skid_valid_ff;
   assign take     = in_valid && in_ready;
   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || take;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_pixel_ff <= skid_valid_ff ? skid_pixel_ff : in_pixel;
      end else if (take) begin
         skid_pixel_ff <= in_pixel;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pixel = out_pixel_ff;

endmodule

`default_nettype wire

[design/raw_value_to_gray_pixel_top.sv]
// Converts a stream of raw little-endian values of one to four bytes into 8-bit gray
// pixels by flatten, linear scale or base-2 logarithm, then applies the selected
// post-processing. One transaction is accepted on every clock while the pipeline is
// not held. The pipeline has three decode and normalise stages, then sixteen
// multiplier stages in which the logarithm squares the normalised mantissa once per
// stage, then one scaling multiplier stage. A two-entry output buffer keeps the input
// ready independent of rsp_ready; when both entries are full the whole pipeline holds.
// Registers are written through the csr_ port and should only change while no
// transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module raw_value_to_gray_pixel_top
   import rvgp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [RawWidth-1:0]      req_raw_value,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [PixWidth-1:0]      rsp_pixel,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam int NumSteps = FracWidth;

   rvgp_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.value_bytes     <= ResetValueBytes;
         cfg_ff.signed_input    <= 1'b0;
         cfg_ff.conversion_mode <= ConvFlatten;
         cfg_ff.post_mode       <= PostNone;
         cfg_ff.log_scale       <= ResetLogScale;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrValueBytes:     cfg_ff.value_bytes     <= csr_wdata[2:0];
            CsrSignedInput:    cfg_ff.signed_input    <= csr_wdata[0];
            CsrConversionMode: cfg_ff.conversion_mode <= csr_wdata[1:0];
            CsrPostMode:       cfg_ff.post_mode       <= csr_wdata[1:0];
            CsrLogScale:       cfg_ff.log_scale       <= csr_wdata[ScaleWidth-1:0];
            default: ;
         endcase
      end
   end

   logic                adv;
   logic                chain_valid [0:NumSteps];
   rvgp_log_type        chain_data  [0:NumSteps];
   logic                back_valid;
   logic [PixWidth-1:0] back_pixel;

   assign req_ready = adv;

   rvgp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .raw_value (req_raw_value),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar k = 0; k < NumSteps; k++) begin : g_step
      rvgp_log_step u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   rvgp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (chain_valid[NumSteps]),
      .in_data   (chain_data[NumSteps]),
      .out_valid (back_valid),
      .out_pixel (back_pixel)
   );

   rvgp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (back_valid),
      .in_pixel  (back_pixel),
      .in_ready  (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pixel (rsp_pixel)
   );

endmodule

`default_nettype wire

[design/rvgp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rvgp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_pixel
);

   // The input may only be held off while a finished pixel is waiting.
   `ASSERT_SAME_CYCLE(a_stall_needs_rsp, clock, reset, !req_ready, rsp_valid, "input stalled with no pixel waiting")

   // An empty output register leaves room for a transaction in the next cycle.
   `ASSERT_NEXT_CYCLE(a_empty_out_ready, clock, reset, !rsp_valid, req_ready, "input not ready after empty output")

   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel), "pixel dropped or changed while stalled")

   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid, "pixel valid after reset")

endmodule

bind raw_value_to_gray_pixel_top rvgp_checker u_rvgp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_pixel (rsp_pixel)
);

`default_nettype wire

[tb/gray_pixel_checker.sv]
`timescale 1ns / 1ps

module gray_pixel_checker
   import rvgp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [RawWidth-1:0]      req_raw_value,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic [PixWidth-1:0]      rsp_pixel,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   output int                            mismatch_count,
   output int                            pixels_pending
);

   rvgp_cfg_type        cfg;
   logic [PixWidth-1:0] expected_pixels [$];
   logic [PixWidth-1:0] want;

   // log2 of a non-zero magnitude with 16 fraction bits, multiplied by the scale and shifted right by ScaleShift.
   function automatic logic [63:0] log_magnitude(input logic [RawWidth-1:0] mag,
                                                 input logic [ScaleWidth-1:0] scale);
      logic [ExpWidth-1:0]  msb;
      logic [63:0]          mant;
      logic [FracWidth-1:0] frac;
      msb = '0;
      for (int i = 1; i < RawWidth; i++) if (mag[i]) msb = ExpWidth'(i);
      // The mantissa sits in [1,2) with 31 fraction bits; each squaring yields one bit.
      mant = {32'd0, mag} << (31 - msb);
      frac = '0;
      for (int k = 0; k < FracWidth; k++) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return (64'({msb, frac}) * 64'(scale)) >> ScaleShift;
   endfunction

   function automatic logic [PixWidth-1:0] predicted_pixel(input rvgp_cfg_type c,
                                                           input logic [RawWidth-1:0] raw);
      int unsigned         nbytes;
      int unsigned         bits;
      int unsigned         shift;
      logic [RawWidth-1:0] mask;
      logic [RawWidth-1:0] u;
      logic [RawWidth-1:0] m;
      logic                neg;
      logic [63:0]         g;
      logic [1:0]          conv;
      logic [PixWidth-1:0] p;
      nbytes = (c.value_bytes == 0) ? 1 : (c.value_bytes > 4) ? 4 : c.value_bytes;
      bits = 8 * nbytes;
      shift = bits - 8;
      mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
      u = raw & mask;
      conv = (c.conversion_mode > ConvLog) ? ConvFlatten : c.conversion_mode;
      if (c.signed_input) begin
         neg = u[bits-1];
         m = neg ? ((~u + 32'd1) & mask) : u;
         case (conv)
            ConvScale: g = m >> shift;
            ConvLog: begin
               g = (m == 0) ? 64'd0 : log_magnitude(m, c.log_scale);
               if (g > PosLimit) g = PosLimit;
            end
            default: begin
               if (neg) g = (m > NegLimit) ? NegLimit : m;
               else g = (m > PosLimit) ? PosLimit : m;
            end
         endcase
         p = neg ? MidLevel - g[PixWidth-1:0] : MidLevel + g[PixWidth-1:0];
      end else begin
         case (conv)
            ConvScale: p = PixWidth'(u >> shift);
            ConvLog: p = (u == 0) ? MinLevel : PixWidth'(log_magnitude(u, c.log_scale));
            default: p = (u > MaxLevel) ? MaxLevel : u[PixWidth-1:0];
         endcase
      end
      case (c.post_mode)
         PostSignum: begin
            if (p > MidLevel) p = MaxLevel;
            else if (p < MidLevel) p = MinLevel;
         end
         PostInvert: p = MaxLevel - p;
         PostZero: p = (p == (c.signed_input ? MidLevel : MinLevel)) ? MinLevel : MaxLevel;
         default: ;
      endcase
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.value_bytes <= ResetValueBytes;
         cfg.signed_input <= 1'b0;
         cfg.conversion_mode <= ConvFlatten;
         cfg.post_mode <= PostNone;
         cfg.log_scale <= ResetLogScale;
         expected_pixels.delete();
         mismatch_count <= 0;
         pixels_pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CsrValueBytes: cfg.value_bytes <= csr_wdata[2:0];
               CsrSignedInput: cfg.signed_input <= csr_wdata[0];
               CsrConversionMode: cfg.conversion_mode <= csr_wdata[1:0];
               CsrPostMode: cfg.post_mode <= csr_wdata[1:0];
               CsrLogScale: cfg.log_scale <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_pixels.push_back(predicted_pixel(cfg, req_raw_value));
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel transaction, expected none, got %0d",
                        $time, rsp_pixel);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel !== want) begin
                  $display("%0t: pixel mismatch, expected %0d, got %0d",
                           $time, want, rsp_pixel);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         pixels_pending <= expected_pixels.size();
      end
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import rvgp_pkg::*;

   localparam logic [1:0] ConvUnused = 2'd3;
   localparam int IdleLimit    = 2000;
   localparam int DrainCycles  = 30;
   localparam int HoldCycles   = 80;
   localparam int RandomPhases = 22;
   localparam int PhaseItems   = 50;
   localparam int HoldPhase    = 4;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [RawWidth-1:0]      req_raw_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [PixWidth-1:0]      rsp_pixel;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;
   int                       mismatch_count;
   int                       pixels_pending;
   bit                       sender_gaps;
   bit                       quiet_tail;
   bit                       hold_output;

   raw_value_to_gray_pixel_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_raw_value (req_raw_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel     (rsp_pixel),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   gray_pixel_checker pixel_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_value  (req_raw_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel      (rsp_pixel),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pixels_pending (pixels_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rvgp_cfg_type make_config(input logic [2:0] nbytes, input logic sgn,
                                                input logic [1:0] conv, input logic [1:0] post,
                                                input logic [ScaleWidth-1:0] scale);
      rvgp_cfg_type c;
      c.value_bytes = nbytes;
      c.signed_input = sgn;
      c.conversion_mode = conv;
      c.post_mode = post;
      c.log_scale = scale;
      return c;
   endfunction

   function automatic rvgp_cfg_type random_config();
      logic [ScaleWidth-1:0] scale;
      logic [2:0]            nbytes;
      case ($urandom_range(0, 4))
         0: scale = '0;
         1: scale = '1;
         2: scale = ResetLogScale;
         3: scale = ScaleWidth'($urandom_range(1 << 12, 1 << 15));
         default: scale = ScaleWidth'($urandom());
      endcase
      // Mostly legal widths, now and then one of the out-of-range codes.
      nbytes = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      return make_config(nbytes, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), scale);
   endfunction

   function automatic logic [RawWidth-1:0] random_raw(input int unsigned width_bits);
      logic [RawWidth-1:0] v;
      logic [RawWidth-1:0] low_mask;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 3);
         1: v = (32'd1 << $urandom_range(0, width_bits - 1)) - $urandom_range(0, 1);
         2: v = (32'd1 << (width_bits - 1)) + $urandom_range(0, 2) - 1;
         3: v = ~32'($urandom_range(0, 3));
         default: v = $urandom();
      endcase
      // Bytes above the set width are ignored by the block, so they carry noise.
      if (width_bits < 32) begin
         low_mask = (32'd1 << width_bits) - 32'd1;
         v = (v & low_mask) | ($urandom() & ~low_mask);
      end
      return v;
   endfunction

   task automatic send_raw(input logic [RawWidth-1:0] value);
      req_valid <= 1'b1;
      req_raw_value <= value;
      do @(posedge clock); while (!req_ready);
      if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
   endtask

   // Registers change only once every pixel in flight has come out.
   task automatic configure(input rvgp_cfg_type c);
      logic [CsrIndexWidth-1:0] index [6];
      logic [CsrDataWidth-1:0]  data [6];
      logic [CsrDataWidth-1:0]  junk;
      drain();
      junk = CsrDataWidth'($urandom());
      index[0] = CsrValueBytes;
      data[0] = {junk[CsrDataWidth-1:3], c.value_bytes};
      index[1] = CsrSignedInput;
      data[1] = {junk[CsrDataWidth-1:1], c.signed_input};
      index[2] = CsrConversionMode;
      data[2] = {junk[CsrDataWidth-1:2], c.conversion_mode};
      // A write to an index with no register behind it must change nothing.
      index[3] = CsrIndexWidth'($urandom_range(CsrLogScale + 1, (1 << CsrIndexWidth) - 1));
      data[3] = CsrDataWidth'($urandom());
      index[4] = CsrPostMode;
      data[4] = {junk[CsrDataWidth-1:2], c.post_mode};
      index[5] = CsrLogScale;
      data[5] = c.log_scale;
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= index[i];
         csr_wdata <= data[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   initial begin : response_sink
      forever begin
         if (hold_output) begin
            rsp_ready <= 1'b0;
            hold_output = 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("raw_value_to_gray_pixel_top verification failed");
      $finish;
   end

   initial begin : stimulus
      rvgp_cfg_type        setting;
      logic [RawWidth-1:0] edge_values [9];
      int unsigned         width_bits;
      req_valid <= 1'b0;
      req_raw_value <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CsrValueBytes;
      csr_wdata <= '0;
      reset <= 1'b1;
      sender_gaps = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The reset settings: one unsigned byte, flatten, no post-processing.
      edge_values = '{32'h0000_0000, 32'h0000_0001, 32'h0000_007F, 32'h0000_0080,
                      32'h0000_00FF, 32'h0000_0100, 32'hFFFF_FF00, 32'hFFFF_FFFF,
                      32'hA5A5_A5FE};
      foreach (edge_values[i]) send_raw(edge_values[i]);

      // Width code zero acts as one byte and the spare conversion code as flatten.
      configure(make_config(3'd0, 1'b1, ConvUnused, PostZero, '0));
      send_raw(32'h0000_0080);
      send_raw(32'h1234_5600);
      // Widest code acts as four bytes; the largest scale makes unsigned log wrap.
      configure(make_config(3'd7, 1'b0, ConvLog, PostNone, '1));
      send_raw(32'hFFFF_FFFF);
      send_raw(32'h0000_0000);
      configure(make_config(3'd4, 1'b1, ConvLog, PostSignum, '1));
      send_raw(32'h8000_0000);
      send_raw(32'h7FFF_FFFF);
      configure(make_config(3'd2, 1'b1, ConvScale, PostInvert, 18'd4096));
      send_raw(32'hABCD_8000);
      send_raw(32'h0000_7FFF);
      configure(make_config(3'd3, 1'b0, ConvScale, PostZero, ResetLogScale));
      send_raw(32'h00FF_FFFF);
      send_raw(32'hFF00_0000);

      for (int phase = 0; phase < RandomPhases; phase++) begin
         setting = random_config();
         configure(setting);
         width_bits = 8 * ((setting.value_bytes == 0) ? 1 :
                           (setting.value_bytes > 4) ? 4 : setting.value_bytes);
         sender_gaps = ($urandom_range(0, 3) != 0);
         quiet_tail = (phase >= RandomPhases - 3);
         // Stall the output for a long stretch while transactions keep coming.
         if (phase == HoldPhase) begin
            sender_gaps = 1'b0;
            hold_output = 1'b1;
         end
         repeat ((phase == HoldPhase) ? 2 * PhaseItems : PhaseItems)
            send_raw(random_raw(width_bits));
      end

      drain();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pixels_pending == 0)
         $display("raw_value_to_gray_pixel_top verification clean");
      else
         $display("raw_value_to_gray_pixel_top verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/rvgp_pkg.sv
design/rvgp_front.sv
design/rvgp_log_step.sv
design/rvgp_back.sv
design/rvgp_out_buf.sv
design/raw_value_to_gray_pixel_top.sv
design/rvgp_checker.sv
tb/gray_pixel_checker.sv
tb/testbench.sv
